>>> rtl/core/awip_pkg.sv
// Package for the adaptive width integer packer.
// Holds the item and result types, the width codes and the code and size tables.
// No dependencies.
package awip_pkg;

	localparam int MAX_ROWS = 16;
	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CNT_W = $clog2(MAX_ROWS + 1);

	localparam logic [2:0] CODE_NONE = 3'd0;
	localparam logic [2:0] CODE_W1 = 3'd1;
	localparam logic [2:0] CODE_W2 = 3'd2;
	localparam logic [2:0] CODE_W4 = 3'd3;
	localparam logic [2:0] CODE_W8 = 3'd4;
	localparam logic [2:0] CODE_W16 = 3'd5;
	localparam logic [2:0] CODE_W32 = 3'd6;

	typedef struct packed {
		logic signed [31:0] value;
		logic last_value;
	} awip_in_t;

	typedef struct packed {
		logic [7:0] packed_byte;
		logic byte_valid;
		logic [2:0] width_code;
		logic [6:0] byte_count;
		logic last_byte;
	} awip_out_t;

	typedef struct packed {
		logic [2:0] code;
		logic [2:0] pos;
	} awip_lane_ctl_t;

	function automatic logic [2:0] row_code(input logic signed [31:0] v);
		logic [2:0] c;
		if (v < 0) begin
			if (v >= -32'sd128) c = CODE_W8;
			else if (v >= -32'sd32768) c = CODE_W16;
			else c = CODE_W32;
		end else begin
			if (v == 32'sd0) c = CODE_NONE;
			else if (v == 32'sd1) c = CODE_W1;
			else if (v <= 32'sd3) c = CODE_W2;
			else if (v <= 32'sd15) c = CODE_W4;
			else if (v <= 32'sd127) c = CODE_W8;
			else if (v <= 32'sd32767) c = CODE_W16;
			else c = CODE_W32;
		end
		return c;
	endfunction

	function automatic logic [6:0] short_bytes(input logic [2:0] code, input logic [2:0] rows);
		logic [6:0] nb;
		nb = 7'd1;
		if (code == CODE_W4 && rows >= 3'd3) nb = 7'd2;
		return nb;
	endfunction

	function automatic logic [2:0] short_code(input logic [2:0] code, input logic [2:0] rows);
		logic [2:0] c;
		c = CODE_W4;
		if (code != CODE_W4 && rows >= 3'd3) c = CODE_W2;
		return c;
	endfunction

	function automatic logic [3:0] sub_bits(input logic [2:0] code);
		logic [3:0] eb;
		unique case (code)
			CODE_W1: eb = 4'd1;
			CODE_W2: eb = 4'd2;
			default: eb = 4'd4;
		endcase
		return eb;
	endfunction

	function automatic logic [1:0] lane_last(input logic [2:0] code);
		logic [1:0] l;
		unique case (code)
			CODE_W16: l = 2'd1;
			CODE_W32: l = 2'd3;
			default: l = 2'd0;
		endcase
		return l;
	endfunction

endpackage

>>> rtl/core/awip_store.sv
// Column store: MAX_ROWS words of 32 bits, one write port, one read port.
// Depends on awip_pkg.
module awip_store
	import awip_pkg::*;
(
	input logic clk,
	input logic we,
	input logic [ROW_W-1:0] waddr,
	input logic [31:0] wdata,
	input logic [ROW_W-1:0] raddr,
	output logic [31:0] rdata
);

	logic [31:0] mem_q [MAX_ROWS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	assign rdata = mem_q[raddr];

endmodule

>>> rtl/core/awip_lane.sv
// Shared byte unit: selects a byte lane of a stored word or merges a sub-byte
// entry into the byte being built. Depends on awip_pkg.
module awip_lane
	import awip_pkg::*;
(
	input awip_lane_ctl_t ctl,
	input logic [7:0] acc,
	input logic [31:0] data,
	output logic [7:0] byte_out
);

	logic [3:0] eb;
	logic [7:0] mask;

	always_comb begin
		eb = sub_bits(ctl.code);
		mask = 8'((9'd1 << eb) - 9'd1);
		if (ctl.code >= CODE_W8) begin
			byte_out = 8'(data >> {ctl.pos[1:0], 3'b000});
		end else begin
			byte_out = acc | 8'((data[7:0] & mask) << ctl.pos);
		end
	end

endmodule

>>> rtl/core/adaptive_width_int_packer_core.sv
// Adaptive width integer packer, top level with the packing sequencer.
// Depends on awip_pkg, awip_store and awip_lane.
//
// Items that are not marked last are taken whenever busy is low and only stored
// (up to MAX_ROWS rows; later ones are dropped). An item marked last is stored
// too and holds busy while the sequencer reads the n stored rows in turn through
// the single store read port to find the width code, sizes the output, then
// emits through the shared byte unit: one byte at a time for 8, 16 and 32-bit
// entries, one row at a time for sub-byte entries (a byte goes out each time it
// fills), nothing for an all-zero column, whose single result is issued by the
// sizing state.
// Each result is shown for one cycle on result with strobe high; the
// receiver cannot stall, so it must take every strobe.
module adaptive_width_int_packer_core
	import awip_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input awip_in_t item,
	output logic strobe,
	output awip_out_t result
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_SIZE = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [CNT_W-1:0] row_cnt_q;
	logic [CNT_W-1:0] n_q;
	logic [ROW_W-1:0] idx_q;
	logic [2:0] code_q;
	logic [2:0] fcode_q;
	logic [6:0] nb_q;
	logic [6:0] k_q;
	logic [2:0] lane_q;
	logic [7:0] acc_q;
	logic strobe_q;
	awip_out_t result_q;

	logic accept;
	logic full;
	logic [31:0] rd_data;
	logic [2:0] rc;
	logic last_row;
	logic [2:0] size_code;
	logic [6:0] size_nb;
	logic [10:0] size_sum;
	logic [7:0] lane_byte;
	logic [3:0] next_pos;
	logic flush;
	logic k_last;
	awip_lane_ctl_t lane_ctl;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign full = (row_cnt_q == CNT_W'(MAX_ROWS));
	assign strobe = strobe_q;
	assign result = result_q;

	awip_store u_store (
		.clk(clk),
		.we(accept && !full),
		.waddr(row_cnt_q[ROW_W-1:0]),
		.wdata(item.value),
		.raddr(idx_q),
		.rdata(rd_data)
	);

	assign lane_ctl = '{code: fcode_q, pos: lane_q};

	awip_lane u_lane (
		.ctl(lane_ctl),
		.acc(acc_q),
		.data(rd_data),
		.byte_out(lane_byte)
	);

	always_comb begin
		rc = row_code(rd_data);
		last_row = (CNT_W'(idx_q) + CNT_W'(1)) == n_q;
		size_sum = (11'(n_q) << code_q) + 11'd14;
		size_code = code_q;
		size_nb = size_sum[10:4];
		if (code_q == CODE_W32) begin
			size_nb = 7'({n_q, 2'b00});
		end else if (n_q < 5 && code_q < CODE_W8) begin
			size_nb = short_bytes(code_q, 3'(n_q));
			size_code = short_code(code_q, 3'(n_q));
		end
		next_pos = {1'b0, lane_q} + sub_bits(fcode_q);
		flush = (next_pos == 4'd8) || last_row;
		k_last = (k_q + 7'd1) == nb_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_cnt_q <= '0;
			n_q <= '0;
			idx_q <= '0;
			code_q <= CODE_NONE;
			fcode_q <= CODE_NONE;
			nb_q <= '0;
			k_q <= '0;
			lane_q <= '0;
			acc_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.last_value) begin
							n_q <= full ? row_cnt_q : row_cnt_q + CNT_W'(1);
							row_cnt_q <= '0;
							idx_q <= '0;
							code_q <= CODE_NONE;
							state_q <= ST_SCAN;
						end else if (!full) begin
							row_cnt_q <= row_cnt_q + CNT_W'(1);
						end
					end
				end
				ST_SCAN: begin
					if (rc > code_q) begin
						code_q <= rc;
					end
					idx_q <= idx_q + ROW_W'(1);
					if (last_row) begin
						idx_q <= '0;
						state_q <= ST_SIZE;
					end
				end
				ST_SIZE: begin
					if (code_q == CODE_NONE) begin
						strobe_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						fcode_q <= size_code;
						nb_q <= size_nb;
						k_q <= '0;
						lane_q <= '0;
						acc_q <= '0;
						idx_q <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (fcode_q >= CODE_W8) begin
						strobe_q <= 1'b1;
						k_q <= k_q + 7'd1;
						if (lane_q[1:0] == lane_last(fcode_q)) begin
							lane_q <= '0;
							idx_q <= idx_q + ROW_W'(1);
						end else begin
							lane_q <= lane_q + 3'd1;
						end
						if (k_last) begin
							state_q <= ST_IDLE;
						end
					end else begin
						idx_q <= idx_q + ROW_W'(1);
						if (flush) begin
							strobe_q <= 1'b1;
							k_q <= k_q + 7'd1;
							acc_q <= '0;
							lane_q <= '0;
							if (k_last) begin
								state_q <= ST_IDLE;
							end
						end else begin
							acc_q <= lane_byte;
							lane_q <= next_pos[2:0];
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SIZE) begin
			result_q <= '{packed_byte: 8'd0, byte_valid: 1'b0, width_code: CODE_NONE,
				byte_count: 7'd0, last_byte: 1'b1};
		end else if (state_q == ST_EMIT) begin
			result_q <= '{packed_byte: lane_byte, byte_valid: 1'b1, width_code: fcode_q,
				byte_count: nb_q, last_byte: k_last};
		end
	end

endmodule
